// File: hdl/ebalu_pkg.sv
`timescale 1ns / 1ps

package ebalu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_CP    = 5'd4,
    OP_AND   = 5'd5,
    OP_OR    = 5'd6,
    OP_XOR   = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_DAA   = 5'd10,
    OP_RLC   = 5'd11,
    OP_RRC   = 5'd12,
    OP_RL    = 5'd13,
    OP_RR    = 5'd14,
    OP_SLA   = 5'd15,
    OP_SRA   = 5'd16,
    OP_SRL   = 5'd17,
    OP_ADD16 = 5'd18,
    OP_SPE   = 5'd19
  } op_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

endpackage

// File: hdl/ebalu_datapath.sv
`timescale 1ns / 1ps

module ebalu_datapath (
  input  logic [4:0]            opcode,
  input  logic [15:0]           value_a,
  input  logic [15:0]           value_b,
  input  logic                  accumulator_form,
  input  ebalu_pkg::flags_t     flags_cur,
  output logic [15:0]           result,
  output logic                  write_back,
  output ebalu_pkg::flags_t     flags_new
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        c_use;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  daa_t1;
  logic [7:0]  daa_res;
  logic        daa_c;
  logic        daa_adj_hi;
  logic        daa_adj_lo;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] sp_ext;
  logic [15:0] sp_res;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;
  logic [7:0]  sh_res;
  logic        sh_co;
  logic [7:0]  res8;

  assign a   = value_a[7:0];
  assign b   = value_b[7:0];
  assign cin = flags_cur.c;

  // Carry-in is only taken for the with-carry forms.
  assign c_use = ((opcode == ebalu_pkg::OP_ADC) || (opcode == ebalu_pkg::OP_SBC)) ? cin : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, c_use};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_use};
  assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, c_use};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_use};

  // Decimal adjust; adding 0x60 leaves the low nibble alone, so the low
  // correction can look at the operand nibble directly.
  assign daa_adj_hi = cin || (a > ebalu_pkg::DAA_HI_LIMIT);
  assign daa_adj_lo = flags_cur.h || (a[3:0] > ebalu_pkg::DAA_LO_LIMIT);
  always_comb begin
    if (!flags_cur.n) begin
      daa_t1  = a + (daa_adj_hi ? ebalu_pkg::DAA_HI_ADJ : 8'd0);
      daa_res = daa_t1 + (daa_adj_lo ? ebalu_pkg::DAA_LO_ADJ : 8'd0);
      daa_c   = daa_adj_hi;
    end else begin
      daa_t1  = a - (cin ? ebalu_pkg::DAA_HI_ADJ : 8'd0);
      daa_res = daa_t1 - (flags_cur.h ? ebalu_pkg::DAA_LO_ADJ : 8'd0);
      daa_c   = cin;
    end
  end

  assign sum17  = {1'b0, value_a} + {1'b0, value_b};
  assign hsum13 = {1'b0, value_a[11:0]} + {1'b0, value_b[11:0]};

  assign sp_ext = {{8{b[7]}}, b};
  assign sp_res = value_a + sp_ext;
  assign sp_h5  = {1'b0, value_a[3:0]} + {1'b0, b[3:0]};
  assign sp_c9  = {1'b0, value_a[7:0]} + {1'b0, b};

  always_comb begin
    case (opcode)
      ebalu_pkg::OP_RLC: begin sh_co = a[7]; sh_res = {a[6:0], a[7]}; end
      ebalu_pkg::OP_RRC: begin sh_co = a[0]; sh_res = {a[0], a[7:1]}; end
      ebalu_pkg::OP_RL:  begin sh_co = a[7]; sh_res = {a[6:0], cin};  end
      ebalu_pkg::OP_RR:  begin sh_co = a[0]; sh_res = {cin, a[7:1]};  end
      ebalu_pkg::OP_SLA: begin sh_co = a[7]; sh_res = {a[6:0], 1'b0}; end
      ebalu_pkg::OP_SRA: begin sh_co = a[0]; sh_res = {a[7], a[7:1]}; end
      default:           begin sh_co = a[0]; sh_res = {1'b0, a[7:1]}; end
    endcase
  end

  always_comb begin
    res8       = 8'd0;
    result     = 16'd0;
    write_back = 1'b1;
    flags_new  = flags_cur;
    case (opcode)
      ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
        res8      = sum9[7:0];
        flags_new = '{z: (res8 == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
        res8       = diff9[7:0];
        flags_new  = '{z: (res8 == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
        result     = {8'd0, res8};
        write_back = (opcode != ebalu_pkg::OP_CP);
      end
      ebalu_pkg::OP_AND: begin
        res8      = a & b;
        flags_new = '{z: (res8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_OR: begin
        res8      = a | b;
        flags_new = '{z: (res8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_XOR: begin
        res8      = a ^ b;
        flags_new = '{z: (res8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_INC: begin
        res8      = a + 8'd1;
        flags_new = '{z: (res8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_DEC: begin
        res8      = a - 8'd1;
        flags_new = '{z: (res8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_DAA: begin
        res8      = daa_res;
        flags_new = '{z: (res8 == 8'd0), n: flags_cur.n, h: 1'b0, c: daa_c};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_RLC, ebalu_pkg::OP_RRC, ebalu_pkg::OP_RL, ebalu_pkg::OP_RR: begin
        res8      = sh_res;
        // The accumulator forms always clear Z.
        flags_new = '{z: (!accumulator_form && (res8 == 8'd0)), n: 1'b0, h: 1'b0, c: sh_co};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_SLA, ebalu_pkg::OP_SRA, ebalu_pkg::OP_SRL: begin
        res8      = sh_res;
        flags_new = '{z: (res8 == 8'd0), n: 1'b0, h: 1'b0, c: sh_co};
        result    = {8'd0, res8};
      end
      ebalu_pkg::OP_ADD16: begin
        result    = sum17[15:0];
        flags_new = '{z: flags_cur.z, n: 1'b0, h: hsum13[12], c: sum17[16]};
      end
      ebalu_pkg::OP_SPE: begin
        result    = sp_res;
        flags_new = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
      end
      default: begin
        result     = 16'd0;
        write_back = 1'b0;
        flags_new  = flags_cur;
      end
    endcase
  end

endmodule

// File: hdl/eight_bit_cpu_alu_with_flags_core.sv
`timescale 1ns / 1ps

// Eight-bit CPU ALU with a Z/N/H/C flag register. Each transaction carries an
// opcode and two operands and produces one result transaction with the value,
// a write-back bit and the new flags, which are also kept for the next
// operation. An operation is captured in an input register, evaluated
// combinationally and lands in the output register; one operation is
// accepted every cycle unless the output stalls. The flag register closes its
// loop in the evaluation stage, so dependent operations also run back to back.
// Output stall holds the output register and backs up into the input stage.

module eight_bit_cpu_alu_with_flags_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_opcode,
  input  logic [15:0] in_value_a,
  input  logic [15:0] in_value_b,
  input  logic        in_accumulator_form,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result,
  output logic        out_write_back,
  output logic        out_flag_zero,
  output logic        out_flag_subtract,
  output logic        out_flag_half,
  output logic        out_flag_carry
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [4:0]        s1_opcode_r;
  logic [15:0]       s1_value_a_r;
  logic [15:0]       s1_value_b_r;
  logic              s1_accf_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [15:0]       out_result_r;
  logic              out_write_back_r;
  ebalu_pkg::flags_t out_flags_r;
  ebalu_pkg::flags_t flags_r;
  ebalu_pkg::flags_t flags_nxt;
  ebalu_pkg::flags_t alu_flags;
  logic [15:0]       alu_result;
  logic              alu_write_back;
  logic              out_free;
  logic              s1_move;
  logic              in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  ebalu_datapath u_datapath (
    .opcode           (s1_opcode_r),
    .value_a          (s1_value_a_r),
    .value_b          (s1_value_b_r),
    .accumulator_form (s1_accf_r),
    .flags_cur        (flags_r),
    .result           (alu_result),
    .write_back       (alu_write_back),
    .flags_new        (alu_flags)
  );

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    flags_nxt     = s1_move ? alu_flags : flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= ebalu_pkg::FLAGS_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r  <= in_opcode;
      s1_value_a_r <= in_value_a;
      s1_value_b_r <= in_value_b;
      s1_accf_r    <= in_accumulator_form;
    end
    if (s1_move) begin
      out_result_r     <= alu_result;
      out_write_back_r <= alu_write_back;
      out_flags_r      <= alu_flags;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_write_back    = out_write_back_r;
  assign out_flag_zero     = out_flags_r.z;
  assign out_flag_subtract = out_flags_r.n;
  assign out_flag_half     = out_flags_r.h;
  assign out_flag_carry    = out_flags_r.c;

`ifndef NO_ASSERTIONS
  // The flags shown with a pending result are the flags the next operation uses.
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flags_r == flags_r))
    else $error("output flags differ from the flag register");

  // The input side only backs up when the input stage is occupied and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked transaction");

  // Flags never change without an operation moving to the output.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(flags_r))
    else $error("flag register changed with no operation");

  // An unknown opcode leaves the flag register untouched.
  a_unknown_op: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (s1_opcode_r > ebalu_pkg::OP_SPE)) |=> (flags_r == $past(flags_r)))
    else $error("unknown opcode changed the flags");
`endif

endmodule
